// ===== src/ghig_pkg.sv =====
// Shared constants and the RN table for the GSM hopping index generator.
`timescale 1ns / 1ps

package ghig_pkg;

	localparam int FN_W   = 22;
	localparam int IDX_W  = 6;
	localparam int OFF_W  = 6;
	localparam int HSN_W  = 6;
	localparam int CNT_W  = 7;
	localparam int CFGA_W = 2;
	localparam int CFGD_W = 7;
	localparam int VAL_W  = 24;

	localparam logic [CFGA_W-1:0] CFG_ALLOC_OFFSET = 2'd0;
	localparam logic [CFGA_W-1:0] CFG_HOP_SEQ      = 2'd1;
	localparam logic [CFGA_W-1:0] CFG_ALLOC_COUNT  = 2'd2;

	localparam logic [10:0] FRAMES_PER_T1 = 11'd1326;
	localparam logic [11:0] RECIP_T1      = 12'd3163;
	localparam logic [4:0]  T2_PERIOD     = 5'd26;
	localparam logic [6:0]  RECIP_T2      = 7'd78;
	localparam logic [5:0]  T3_PERIOD     = 6'd51;
	localparam logic [5:0]  RECIP_T3      = 6'd40;
	localparam logic [6:0]  RN_LAST       = 7'd113;

	localparam logic [6:0] RN_TABLE [0:113] = '{
		7'd48,  7'd98,  7'd63,  7'd1,   7'd36,  7'd95,  7'd78,  7'd102, 7'd94,  7'd73,
		7'd0,   7'd64,  7'd25,  7'd81,  7'd76,  7'd59,  7'd124, 7'd23,  7'd104, 7'd100,
		7'd101, 7'd47,  7'd118, 7'd85,  7'd18,  7'd56,  7'd96,  7'd86,  7'd54,  7'd2,
		7'd80,  7'd34,  7'd127, 7'd13,  7'd6,   7'd89,  7'd57,  7'd103, 7'd12,  7'd74,
		7'd55,  7'd111, 7'd75,  7'd38,  7'd109, 7'd71,  7'd112, 7'd29,  7'd11,  7'd88,
		7'd87,  7'd19,  7'd3,   7'd68,  7'd110, 7'd26,  7'd33,  7'd31,  7'd8,   7'd45,
		7'd82,  7'd58,  7'd40,  7'd107, 7'd32,  7'd5,   7'd106, 7'd92,  7'd62,  7'd67,
		7'd77,  7'd108, 7'd122, 7'd37,  7'd60,  7'd66,  7'd121, 7'd42,  7'd51,  7'd126,
		7'd117, 7'd114, 7'd4,   7'd90,  7'd43,  7'd52,  7'd53,  7'd113, 7'd120, 7'd72,
		7'd16,  7'd49,  7'd7,   7'd79,  7'd119, 7'd61,  7'd22,  7'd84,  7'd9,   7'd97,
		7'd91,  7'd15,  7'd21,  7'd24,  7'd46,  7'd39,  7'd93,  7'd105, 7'd65,  7'd70,
		7'd125, 7'd99,  7'd17,  7'd123
	};

endpackage

// ===== src/gsm_hopping_index_generator.sv =====
// Pipelined GSM mobile allocation index generator.
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata[21:0] frame_num
// m_       out  m_tvalid/m_tready    m_tdata[5:0]  alloc_index
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (0 offset, 1 hsn, 2 count)
//
// One beat per cycle while s_tready is high; each result passes eleven further
// pipeline stages after the one that takes its beat (frame split, RN lookup,
// 24-bit mod-n reduction at six bits a stage) and then the output register.
// All stages advance together; a skid register behind the output register
// absorbs one result, and s_tready falls only while it is full.
// Reset clears valid bits and loads offset 0, hsn 0, count 1.
`timescale 1ns / 1ps

module gsm_hopping_index_generator #(
	parameter int MAX_ALLOC = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,   // [21:0] frame_num
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,   // [5:0] alloc_index
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ghig_pkg::CFGA_W-1:0]  cfg_index,
	input  logic [ghig_pkg::CFGD_W-1:0]  cfg_data
);
	import ghig_pkg::*;

	localparam logic [CNT_W-1:0] MaxN = CNT_W'(MAX_ALLOC);

	function automatic logic [5:0] mod_step6(input logic [5:0] rem, input logic [5:0] bits,
			input logic [6:0] n);
		logic [6:0] acc;
		logic [5:0] r;
		r = rem;
		for (int i = 5; i >= 0; i--) begin
			acc = {r, bits[i]};
			if (acc >= n) begin
				acc = acc - n;
			end
			r = acc[5:0];
		end
		return r;
	endfunction

	logic [OFF_W-1:0] alloc_offset_q;
	logic [HSN_W-1:0] hop_seq_number_q;
	logic [CNT_W-1:0] alloc_count_q;
	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] mask;

	logic en;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, v7_s7, v8_s8;
	logic v9_s9, v10_s10, v11_s11, v12_s12;

	logic [FN_W-1:0] fn_s1, fn_s2, fn_s3, fn_s4, fn_s5, fn_s6, fn_s7;
	logic [11:0]     qe_s2, qe_s3;
	logic [21:0]     prod_s3;
	logic [5:0]      t1r_s4, t1r_s5, t1r_s6;
	logic [10:0]     r_s4, r_s5;
	logic [5:0]      qa_s5;
	logic [4:0]      qb_s5;
	logic [4:0]      t2_s6;
	logic [5:0]      t3_s6, t3_s7;
	logic [7:0]      m_s7;
	logic [VAL_W-1:0] val_s8, val_s9, val_s10, val_s11;
	logic [5:0]      rem_s9, rem_s10, rem_s11, rem_s12;

	logic [IDX_W-1:0] out_q, skid_q;
	logic             out_valid_q, skid_valid_q;
	logic             out_free;

	logic [33:0] mul1;
	logic [22:0] mul2;
	logic [21:0] rdiff;
	logic [11:0] r0;
	logic [16:0] mula;
	logic [15:0] mulb;
	logic [10:0] da_full, db_full;
	logic [5:0]  da;
	logic [6:0]  db;
	logic [6:0]  idx, idx_c;
	logic [7:0]  mp, tp;
	logic [8:0]  sel;

	assign n_eff = (alloc_count_q == '0) ? CNT_W'(1) :
		(alloc_count_q > MaxN) ? MaxN : alloc_count_q;
	assign mask = n_eff | (n_eff >> 1) | (n_eff >> 2) | (n_eff >> 3) |
		(n_eff >> 4) | (n_eff >> 5) | (n_eff >> 6);

	assign en        = !skid_valid_q;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {2'b00, out_q};

	assign mul1    = 34'(fn_s1) * 34'(RECIP_T1);
	assign mul2    = 23'(qe_s2) * 23'(FRAMES_PER_T1);
	assign rdiff   = fn_s3 - prod_s3;
	assign r0      = rdiff[11:0];
	assign mula    = 17'(r_s4) * 17'(RECIP_T2);
	assign mulb    = 16'(r_s4) * 16'(RECIP_T3);
	assign da_full = r_s5 - 11'(qa_s5 * 11'(T2_PERIOD));
	assign db_full = r_s5 - 11'(qb_s5 * 11'(T3_PERIOD));
	assign da      = da_full[5:0];
	assign db      = db_full[6:0];
	assign idx     = 7'(hop_seq_number_q ^ t1r_s6) + 7'(t3_s6);
	assign idx_c   = (idx > RN_LAST) ? RN_LAST : idx;
	assign mp      = m_s7 & {1'b0, mask};
	assign tp      = {2'b00, t3_s7} & {1'b0, mask};
	assign sel     = (mp < {1'b0, n_eff}) ? {1'b0, mp} : 9'(mp) + 9'(tp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_offset_q   <= '0;
			hop_seq_number_q <= '0;
			alloc_count_q    <= CNT_W'(1);
			{v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6} <= '0;
			{v7_s7, v8_s8, v9_s9, v10_s10, v11_s11, v12_s12} <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ALLOC_OFFSET: alloc_offset_q   <= cfg_data[OFF_W-1:0];
					CFG_HOP_SEQ:      hop_seq_number_q <= cfg_data[HSN_W-1:0];
					CFG_ALLOC_COUNT:  alloc_count_q    <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (en) begin
				v1_s1   <= s_tvalid;
				v2_s2   <= v1_s1;
				v3_s3   <= v2_s2;
				v4_s4   <= v3_s3;
				v5_s5   <= v4_s4;
				v6_s6   <= v5_s5;
				v7_s7   <= v6_s6;
				v8_s8   <= v7_s7;
				v9_s9   <= v8_s8;
				v10_s10 <= v9_s9;
				v11_s11 <= v10_s10;
				v12_s12 <= v11_s11;
			end
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= v12_s12;
				end
			end else if (en && v12_s12) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fn_s1   <= s_tdata[FN_W-1:0];
			fn_s2   <= fn_s1;
			qe_s2   <= mul1[33:22];
			fn_s3   <= fn_s2;
			qe_s3   <= qe_s2;
			prod_s3 <= mul2[21:0];
			fn_s4   <= fn_s3;
			if (r0 >= 12'(FRAMES_PER_T1)) begin
				r_s4   <= 11'(r0 - 12'(FRAMES_PER_T1));
				t1r_s4 <= 6'(qe_s3 + 12'd1);
			end else begin
				r_s4   <= r0[10:0];
				t1r_s4 <= qe_s3[5:0];
			end
			fn_s5   <= fn_s4;
			t1r_s5  <= t1r_s4;
			r_s5    <= r_s4;
			qa_s5   <= mula[16:11];
			qb_s5   <= mulb[15:11];
			fn_s6   <= fn_s5;
			t1r_s6  <= t1r_s5;
			t2_s6   <= (da >= 6'(T2_PERIOD)) ? 5'(da - 6'(T2_PERIOD)) : da[4:0];
			t3_s6   <= (db >= 7'(T3_PERIOD)) ? 6'(db - 7'(T3_PERIOD)) : db[5:0];
			fn_s7   <= fn_s6;
			t3_s7   <= t3_s6;
			m_s7    <= 8'(t2_s6) + 8'(RN_TABLE[idx_c]);
			val_s8  <= (hop_seq_number_q == '0) ?
				VAL_W'(fn_s7) + VAL_W'(alloc_offset_q) :
				VAL_W'(sel) + VAL_W'(alloc_offset_q);
			val_s9  <= val_s8;
			rem_s9  <= mod_step6(6'd0, val_s8[23:18], n_eff);
			val_s10 <= val_s9;
			rem_s10 <= mod_step6(rem_s9, val_s9[17:12], n_eff);
			val_s11 <= val_s10;
			rem_s11 <= mod_step6(rem_s10, val_s10[11:6], n_eff);
			rem_s12 <= mod_step6(rem_s11, val_s11[5:0], n_eff);
		end
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : rem_s12;
		end else if (en && v12_s12) begin
			skid_q <= rem_s12;
		end
	end

endmodule

// ===== src/ghig_checker.sv =====
// Port-level assertions for the GSM hopping index generator, bound to the top level.
`timescale 1ns / 1ps

module ghig_checker #(
	parameter int MAX_ALLOC = 64
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [7:0]                  m_tdata,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [ghig_pkg::CFGA_W-1:0] cfg_index,
	input logic [ghig_pkg::CFGD_W-1:0] cfg_data
);
	import ghig_pkg::*;

	localparam logic [CNT_W-1:0] MaxN = CNT_W'(MAX_ALLOC);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_chk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready && cfg_index == CFG_ALLOC_COUNT) begin
			count_q <= cfg_data[CNT_W-1:0];
		end
	end

	assign n_chk = (count_q == '0) ? CNT_W'(1) : (count_q > MaxN) ? MaxN : count_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:6] == 2'b00)
		else $error("padding bits of m_tdata not zero");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, m_tdata[5:0]} < n_chk)
		else $error("alloc_index not below channel count");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

endmodule

bind gsm_hopping_index_generator ghig_checker #(.MAX_ALLOC(MAX_ALLOC)) u_ghig_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
